// File: hdl/tpa_pkg.sv
// ----------------------------------------------------------------------------
// Tensor permute address generator package
// Shared widths, register indexes, planner states and the result record.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int MAX_RANK     = 4;
    localparam int DIM_BITS     = 16;
    localparam int ADDR_BITS    = 32;
    localparam int DATA_BITS    = 64;
    localparam int RANK_BITS    = 3;
    localparam int DIM_IDX_BITS = $clog2(MAX_RANK);
    localparam int PERM_BITS    = 8;
    localparam int ACC_BITS     = ADDR_BITS + 1;
    localparam int PROD_BITS    = ACC_BITS + DIM_BITS;
    localparam int WRAP_BITS    = ADDR_BITS + DIM_BITS;
    localparam int PADDR_BITS   = 5;
    localparam int PDATA_BITS   = 32;

    // Largest legal element count is exactly 2^ADDR_BITS.
    localparam logic [PROD_BITS-1:0] ACC_LIMIT = PROD_BITS'(1) << ADDR_BITS;

    localparam logic [RANK_BITS-1:0] RANK_RESET = RANK_BITS'(4);
    localparam logic [DIM_BITS-1:0]  SIZE_RESET = DIM_BITS'(1);
    localparam logic [PERM_BITS-1:0] PERM_RESET = PERM_BITS'(27);

    typedef logic [DIM_IDX_BITS-1:0] t_dim_idx;

    typedef enum logic [2:0] {
        REG_RANK  = 3'd0,
        REG_SIZE0 = 3'd1,
        REG_SIZE1 = 3'd2,
        REG_SIZE2 = 3'd3,
        REG_SIZE3 = 3'd4,
        REG_PERM  = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_CHECK,
        ST_STRIDE,
        ST_WRAP_MUL,
        ST_WRAP_ACC,
        ST_READY
    } t_plan_state;

    typedef struct packed {
        logic [ADDR_BITS-1:0] dest_index;
        logic [DATA_BITS-1:0] out_value;
        logic                 last_elem;
        logic                 cfg_error;
    } t_result;

    // Source dimension feeding output dimension d.
    function automatic t_dim_idx perm_field(input logic [PERM_BITS-1:0] order,
                                            input t_dim_idx d);
        perm_field = order[{d, 1'b0} +: DIM_IDX_BITS];
    endfunction

endpackage

// File: hdl/tensor_permute_address_gen.sv
// ----------------------------------------------------------------------------
// Tensor permute address generator
// Streams row-major source elements and tags each with its row-major index
// in the permuted tensor, using a source-digit odometer and a running index.
// Results are registered; one item per cycle while o_ready is high.
// After reset and after every register write a planner runs (a check, up to
// four stride multiplies, up to four wrap multiply/accumulate pairs) while
// o_ready is low. Reset is synchronous active low, loads the register reset
// values and clears the odometer and the running index.
// ----------------------------------------------------------------------------
module tensor_permute_address_gen
    import tpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DATA_BITS-1:0]  i_elem_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ADDR_BITS-1:0]  o_dest_index,
    output logic [DATA_BITS-1:0]  o_out_value,
    output logic                  o_last_elem,
    output logic                  o_cfg_error,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    // Configuration registers
    logic [RANK_BITS-1:0] r_rank;
    logic [DIM_BITS-1:0]  r_size [MAX_RANK];
    logic [PERM_BITS-1:0] r_perm;

    // Planner
    t_plan_state          r_state, n_state;
    t_dim_idx             r_idx;
    logic [ACC_BITS-1:0]  r_acc;
    logic [ADDR_BITS-1:0] r_dstr  [MAX_RANK];
    logic [ADDR_BITS-1:0] r_delta [MAX_RANK];
    logic [ADDR_BITS-1:0] r_wrap;
    logic [ADDR_BITS-1:0] r_cum;
    logic                 r_cfg_bad;

    // Odometer
    logic [DIM_BITS-1:0]  r_digit [MAX_RANK];
    logic [ADDR_BITS-1:0] r_dest;

    // Output stage with skid
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    logic                  w_cfg_wr;
    logic [2:0]            w_reg_idx;
    logic                  w_plan_ok;
    t_dim_idx              w_last_dim;
    t_dim_idx              w_src;
    t_dim_idx              w_size_addr;
    logic [DIM_BITS-1:0]   w_size_rd;
    logic [PROD_BITS-1:0]  w_prod;
    logic                  w_ovf;
    logic [WRAP_BITS-1:0]  w_wrap_full;
    logic [MAX_RANK-1:0]   w_inc, w_clr;
    logic                  w_last;
    logic [ADDR_BITS-1:0]  w_delta_sel;
    logic                  w_in_take, w_out_take;
    t_result               w_result;

    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_reg_idx = paddr[4:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= RANK_RESET;
            r_perm <= PERM_RESET;
            for (int i = 0; i < MAX_RANK; i++) begin
                r_size[i] <= SIZE_RESET;
            end
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_RANK:  r_rank    <= pwdata[RANK_BITS-1:0];
                REG_SIZE0: r_size[0] <= pwdata[DIM_BITS-1:0];
                REG_SIZE1: r_size[1] <= pwdata[DIM_BITS-1:0];
                REG_SIZE2: r_size[2] <= pwdata[DIM_BITS-1:0];
                REG_SIZE3: r_size[3] <= pwdata[DIM_BITS-1:0];
                REG_PERM:  r_perm    <= pwdata[PERM_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_RANK:  prdata = PDATA_BITS'(r_rank);
            REG_SIZE0: prdata = PDATA_BITS'(r_size[0]);
            REG_SIZE1: prdata = PDATA_BITS'(r_size[1]);
            REG_SIZE2: prdata = PDATA_BITS'(r_size[2]);
            REG_SIZE3: prdata = PDATA_BITS'(r_size[3]);
            REG_PERM:  prdata = PDATA_BITS'(r_perm);
            default:   prdata = '0;
        endcase
    end

    // Rank range, permutation and nonzero extents of the dimensions in use.
    always_comb begin : plan_check
        logic [MAX_RANK-1:0] v_seen;
        t_dim_idx            v_p;
        v_seen    = '0;
        w_plan_ok = (r_rank != '0) && (r_rank <= RANK_BITS'(MAX_RANK));
        for (int d = 0; d < MAX_RANK; d++) begin
            v_p = perm_field(r_perm, DIM_IDX_BITS'(d));
            if (RANK_BITS'(d) < r_rank) begin
                if ((RANK_BITS'(v_p) >= r_rank) || v_seen[v_p] || (r_size[d] == '0)) begin
                    w_plan_ok = 1'b0;
                end
                v_seen[v_p] = 1'b1;
            end
        end
    end

    assign w_last_dim  = DIM_IDX_BITS'(r_rank - 1'b1);
    assign w_src       = perm_field(r_perm, r_idx);
    assign w_size_addr = (r_state == ST_STRIDE) ? w_src : r_idx;
    assign w_size_rd   = r_size[w_size_addr];
    assign w_prod      = PROD_BITS'(r_acc) * PROD_BITS'(w_size_rd);
    assign w_ovf       = w_prod > ACC_LIMIT;
    assign w_wrap_full = WRAP_BITS'(w_size_rd - 1'b1) * WRAP_BITS'(r_dstr[r_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CHECK;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CHECK:    n_state = w_plan_ok ? ST_STRIDE : ST_READY;
            ST_STRIDE: begin
                if (w_ovf) begin
                    n_state = ST_READY;
                end else if (r_idx == '0) begin
                    n_state = ST_WRAP_MUL;
                end
            end
            ST_WRAP_MUL: n_state = ST_WRAP_ACC;
            ST_WRAP_ACC: n_state = (r_idx == '0) ? ST_READY : ST_WRAP_MUL;
            ST_READY:    n_state = ST_READY;
            default:     n_state = ST_CHECK;
        endcase
        if (w_cfg_wr) begin
            n_state = ST_CHECK;
        end
    end

    // Strides per source dimension in destination order, then for each
    // source dimension the index step when it advances and all faster
    // dimensions wrap back from their maximum digit.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_CHECK: begin
                r_idx <= w_last_dim;
                r_acc <= ACC_BITS'(1);
            end
            ST_STRIDE: begin
                r_dstr[w_src] <= r_acc[ADDR_BITS-1:0];
                r_acc         <= w_prod[ACC_BITS-1:0];
                r_cum         <= '0;
                r_idx         <= (r_idx == '0) ? w_last_dim : r_idx - 1'b1;
            end
            ST_WRAP_MUL: begin
                r_wrap <= w_wrap_full[ADDR_BITS-1:0];
            end
            ST_WRAP_ACC: begin
                r_delta[r_idx] <= r_dstr[r_idx] - r_cum;
                r_cum          <= r_cum + r_wrap;
                r_idx          <= r_idx - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bad <= 1'b0;
        end else if (r_state == ST_CHECK) begin
            r_cfg_bad <= !w_plan_ok;
        end else if (r_state == ST_STRIDE && w_ovf) begin
            r_cfg_bad <= 1'b1;
        end
    end

    // Odometer carry from the fastest dimension in use.
    always_comb begin : carry
        logic v_done;
        v_done      = 1'b0;
        w_inc       = '0;
        w_clr       = '0;
        w_delta_sel = '0;
        for (int s = MAX_RANK - 1; s >= 0; s--) begin
            if ((RANK_BITS'(s) < r_rank) && !v_done) begin
                if ((DIM_BITS + 1)'(r_digit[s]) + 1'b1 < (DIM_BITS + 1)'(r_size[s])) begin
                    w_inc[s]    = 1'b1;
                    w_delta_sel = r_delta[s];
                    v_done      = 1'b1;
                end else begin
                    w_clr[s] = 1'b1;
                end
            end
        end
        w_last = !v_done;
    end

    assign o_ready    = (r_state == ST_READY) && !r_skid_valid;
    assign w_in_take  = i_valid & o_ready;
    assign w_out_take = r_out_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_wr) begin
            r_dest <= '0;
            for (int s = 0; s < MAX_RANK; s++) begin
                r_digit[s] <= '0;
            end
        end else if (w_in_take && !r_cfg_bad) begin
            r_dest <= w_last ? '0 : r_dest + w_delta_sel;
            for (int s = 0; s < MAX_RANK; s++) begin
                if (w_inc[s]) begin
                    r_digit[s] <= r_digit[s] + 1'b1;
                end else if (w_clr[s]) begin
                    r_digit[s] <= '0;
                end
            end
        end
    end

    always_comb begin
        w_result.dest_index = r_cfg_bad ? '0 : r_dest;
        w_result.out_value  = i_elem_value;
        w_result.last_elem  = !r_cfg_bad && w_last;
        w_result.cfg_error  = r_cfg_bad;
    end

    // A result that cannot leave goes to the skid register, so one more
    // item is taken while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_take) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (w_in_take) begin
                r_out <= w_result;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (w_in_take) begin
            if (!r_out_valid) begin
                r_out       <= w_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= w_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_dest_index = r_out.dest_index;
    assign o_out_value  = r_out.out_value;
    assign o_last_elem  = r_out.last_elem;
    assign o_cfg_error  = r_out.cfg_error;

`ifndef ASSERT_OFF
    a_no_ready_while_planning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_READY) |-> !o_ready)
        else $error("input ready while strides are being planned");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the output is empty");

    a_cfg_write_replans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (!o_ready && r_dest == '0))
        else $error("register write did not restart the tensor");

    a_error_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cfg_error) |-> (o_dest_index == '0 && !o_last_elem))
        else $error("error result carries an index or last flag");
`endif

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Tensor permute address generator testbench
// Streams random source elements through the block under many tensor shapes
// and permutations, predicts each destination index, last flag and error
// flag, and compares every result in order. Both handshake sides idle and
// stall at random; registers are rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
module testbench;
    import tpa_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS   = 400;
    // Index with no register behind it; a write there still restarts the tensor.
    localparam logic [2:0]  REG_SPARE      = 3'd6;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers and the odometer.
    // ------------------------------------------------------------------------
    class permute_scoreboard;
        logic [RANK_BITS-1:0] cfg_rank;
        logic [DIM_BITS-1:0]  cfg_size [MAX_RANK];
        logic [PERM_BITS-1:0] cfg_perm;
        longint unsigned      src_digit [MAX_RANK];
        longint unsigned      dest_pos;
        t_result              pending_results [$];
        int unsigned          err_count;

        function new();
            err_count = 0;
            cfg_rank  = RANK_RESET;
            cfg_perm  = PERM_RESET;
            for (int d = 0; d < MAX_RANK; d++) cfg_size[d] = SIZE_RESET;
            restart();
        endfunction

        function void restart();
            for (int d = 0; d < MAX_RANK; d++) src_digit[d] = 0;
            dest_pos = 0;
        endfunction

        function void report(string what);
            err_count++;
            $display("ERROR at %0t: %s", $time, what);
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void config_write(logic [2:0] idx, logic [PDATA_BITS-1:0] value);
            case (idx)
                REG_RANK: cfg_rank = value[RANK_BITS-1:0];
                REG_SIZE0, REG_SIZE1, REG_SIZE2, REG_SIZE3:
                    cfg_size[idx - REG_SIZE0] = value[DIM_BITS-1:0];
                REG_PERM: cfg_perm = value[PERM_BITS-1:0];
                default: ;
            endcase
            restart();
        endfunction

        // Checks the shape and gives the destination stride of each source
        // dimension; returns 0 when the configuration is unusable.
        function bit plan_strides(output longint unsigned stride [MAX_RANK]);
            int              r;
            int unsigned     src [MAX_RANK];
            bit              seen [MAX_RANK];
            longint unsigned acc;
            longint unsigned limit;
            int unsigned     p;
            r     = cfg_rank;
            acc   = 1;
            limit = 64'd1 << ADDR_BITS;
            for (int d = 0; d < MAX_RANK; d++) begin
                stride[d] = 0;
                seen[d]   = 0;
                src[d]    = 0;
            end
            if (r < 1 || r > MAX_RANK) return 0;
            for (int d = 0; d < r; d++) begin
                p = cfg_perm[2*d +: 2];
                if (p >= r || seen[p]) return 0;
                seen[p] = 1;
                src[d]  = p;
            end
            for (int d = 0; d < r; d++)
                if (cfg_size[d] == 0) return 0;
            for (int d = r - 1; d >= 0; d--) begin
                stride[src[d]] = acc;
                if (acc > limit / cfg_size[src[d]]) return 0;
                acc = acc * cfg_size[src[d]];
            end
            return 1;
        endfunction

        function void note_input(logic [DATA_BITS-1:0] value);
            longint unsigned stride [MAX_RANK];
            t_result         want;
            bit              wrapped;
            want.out_value = value;
            if (!plan_strides(stride)) begin
                want.dest_index = '0;
                want.last_elem  = 1'b0;
                want.cfg_error  = 1'b1;
            end else begin
                want.dest_index = dest_pos[ADDR_BITS-1:0];
                want.cfg_error  = 1'b0;
                wrapped = 1;
                // Odometer step, fastest digit first.
                for (int s = int'(cfg_rank) - 1; s >= 0; s--) begin
                    if (src_digit[s] + 1 < cfg_size[s]) begin
                        src_digit[s]++;
                        dest_pos += stride[s];
                        wrapped = 0;
                        break;
                    end
                    dest_pos -= src_digit[s] * stride[s];
                    src_digit[s] = 0;
                end
                if (wrapped) dest_pos = 0;
                dest_pos &= (64'd1 << ADDR_BITS) - 1;
                want.last_elem = wrapped;
            end
            pending_results.push_back(want);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing expected, index %0h", got.dest_index));
                return;
            end
            want = pending_results.pop_front();
            if (got.dest_index !== want.dest_index)
                report($sformatf("dest_index %0h, expected %0h",
                                 got.dest_index, want.dest_index));
            if (got.out_value !== want.out_value)
                report($sformatf("out_value %0h, expected %0h",
                                 got.out_value, want.out_value));
            if (got.last_elem !== want.last_elem)
                report($sformatf("last_elem %0b, expected %0b",
                                 got.last_elem, want.last_elem));
            if (got.cfg_error !== want.cfg_error)
                report($sformatf("cfg_error %0b, expected %0b",
                                 got.cfg_error, want.cfg_error));
        endfunction
    endclass

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic [DATA_BITS-1:0]  i_elem_value = '0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    logic [ADDR_BITS-1:0]  o_dest_index;
    logic [DATA_BITS-1:0]  o_out_value;
    logic                  o_last_elem;
    logic                  o_cfg_error;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [PADDR_BITS-1:0] paddr        = '0;
    logic [PDATA_BITS-1:0] pwdata       = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    permute_scoreboard sb;
    int unsigned       sent_count     = 0;
    int unsigned       src_idle_pct   = 32;
    int unsigned       sink_stall_pct = 71;
    int unsigned       quiet_cycles   = 0;

    tensor_permute_address_gen u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_elem_value (i_elem_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_dest_index (o_dest_index),
        .o_out_value  (o_out_value),
        .o_last_elem  (o_last_elem),
        .o_cfg_error  (o_cfg_error),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(t_result'({o_dest_index, o_out_value, o_last_elem, o_cfg_error}));
    end

    // Ends the run if nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [PERM_BITS-1:0] perm_code(int unsigned p0, int unsigned p1,
                                                       int unsigned p2, int unsigned p3);
        return PERM_BITS'(p0 | (p1 << 2) | (p2 << 4) | (p3 << 6));
    endfunction

    // Fills the bits above a register's width with noise the block must ignore.
    function automatic logic [PDATA_BITS-1:0] with_junk(int unsigned v, int unsigned w);
        return ($urandom() << w) | v;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the caller either sends again or stops.
    task automatic send_elem(input logic [DATA_BITS-1:0] value);
        if (sent_count < 140) begin
            src_idle_pct   = 32;
            sink_stall_pct = 71;
        end else if (sent_count < 280) begin
            src_idle_pct   = 71;
            sink_stall_pct = 32;
        end else begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_elem_value <= value;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(value);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_rand_elem();
        case ($urandom_range(15))
            0: send_elem('0);
            1: send_elem('1);
            default: send_elem({$urandom(), $urandom()});
        endcase
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.config_write(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_config(input int unsigned rank_v, input int unsigned s0,
                                input int unsigned s1, input int unsigned s2,
                                input int unsigned s3, input logic [PERM_BITS-1:0] perm_v);
        pause_until_drained();
        write_reg(REG_RANK,  with_junk(rank_v, RANK_BITS));
        write_reg(REG_SIZE0, with_junk(s0, DIM_BITS));
        write_reg(REG_SIZE1, with_junk(s1, DIM_BITS));
        write_reg(REG_SIZE2, with_junk(s2, DIM_BITS));
        write_reg(REG_SIZE3, with_junk(s3, DIM_BITS));
        write_reg(REG_PERM,  with_junk(32'(perm_v), PERM_BITS));
    endtask

    initial begin : stimulus
        int unsigned          rand_items;
        int unsigned          n_items;
        int unsigned          rk;
        int unsigned          sz [MAX_RANK];
        int unsigned          order [MAX_RANK];
        int unsigned          j;
        int unsigned          pick;
        int unsigned          tmp;
        logic [PERM_BITS-1:0] code;
        longint unsigned      total;

        sb = new();
        rand_items = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset shape holds one element, so every element ends a tensor.
        send_elem('0);
        send_elem('1);
        send_elem(64'hA5A5_0F0F_3C3C_9696);
        apply_config(2, 2, 3, 0, 0, perm_code(1, 0, 0, 0));
        repeat (7) send_rand_elem();
        apply_config(1, 65535, 0, 0, 0, perm_code(0, 3, 3, 3));
        repeat (2) send_rand_elem();
        // Exactly 2^32 elements is still a legal tensor; a larger one is not.
        apply_config(4, 256, 256, 256, 256, perm_code(0, 1, 2, 3));
        repeat (2) send_rand_elem();
        apply_config(4, 256, 256, 256, 257, perm_code(3, 2, 1, 0));
        send_rand_elem();
        apply_config(0, 1, 1, 1, 1, perm_code(0, 0, 0, 0));
        send_rand_elem();
        apply_config(5, 1, 1, 1, 1, perm_code(3, 2, 1, 0));
        send_rand_elem();
        apply_config(3, 2, 2, 2, 1, perm_code(0, 0, 1, 0));
        send_rand_elem();
        apply_config(3, 2, 2, 2, 1, perm_code(3, 1, 0, 0));
        send_rand_elem();
        apply_config(3, 2, 0, 2, 1, perm_code(2, 0, 1, 0));
        send_rand_elem();
        // A write to an unused index restarts the tensor part way through.
        apply_config(3, 2, 2, 2, 1, perm_code(2, 0, 1, 0));
        repeat (3) send_rand_elem();
        pause_until_drained();
        write_reg(REG_SPARE, $urandom());
        repeat (3) send_rand_elem();

        while (rand_items < RANDOM_ITEMS) begin
            if ($urandom_range(9) < 8) begin
                rk = $urandom_range(1, MAX_RANK);
                for (j = 0; j < MAX_RANK; j++) order[j] = j;
                for (j = rk - 1; j > 0; j--) begin
                    pick        = $urandom_range(j);
                    tmp         = order[j];
                    order[j]    = order[pick];
                    order[pick] = tmp;
                end
                code = PERM_BITS'($urandom());
                for (j = 0; j < rk; j++) code[2*j +: 2] = order[j][1:0];
                for (j = 0; j < MAX_RANK; j++)
                    sz[j] = (j < rk) ? $urandom_range(1, 3) : $urandom_range(65535);
                if ($urandom_range(9) == 0)
                    sz[$urandom_range(rk - 1)] = $urandom_range(1) ? 65535
                                                                   : $urandom_range(1, 65535);
            end else begin
                rk   = $urandom_range(7);
                code = PERM_BITS'($urandom());
                for (j = 0; j < MAX_RANK; j++) begin
                    case ($urandom_range(3))
                        0: sz[j] = 0;
                        1: sz[j] = $urandom_range(65535);
                        default: sz[j] = $urandom_range(1, 3);
                    endcase
                end
            end
            total = 1;
            for (j = 0; j < rk && j < MAX_RANK; j++) total *= sz[j];
            // Small tensors run through whole at least once, so wraps are seen.
            if (total >= 1 && total <= 81)
                n_items = 32'(total) * $urandom_range(1, 2) + $urandom_range(2);
            else
                n_items = $urandom_range(1, 12);
            apply_config(rk, sz[0], sz[1], sz[2], sz[3], code);
            repeat (n_items) begin
                if (rand_items == RANDOM_ITEMS / 2) pause_until_drained();
                send_rand_elem();
                rand_items++;
            end
        end

        pause_until_drained();
        repeat (4) @(posedge i_clk);
        if (sb.err_count == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
hdl/tpa_pkg.sv
hdl/tensor_permute_address_gen.sv
tb/sv/testbench.sv
